// ===== hdl/i2c_rts_pkg.sv =====
// shared constants for the i2c register transfer sequencer
// limits, field widths, byte engine status codes, action, result and request codes
// no dependencies
package i2c_rts_pkg;

  localparam int unsigned MaxAddrBytes = 4;
  localparam int unsigned MaxTransfer  = 4096;

  localparam int unsigned ActW   = 3;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned LenW   = 3;
  localparam int unsigned CountW = 13;
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 24;

  // byte engine status codes
  localparam logic [7:0] StStart     = 8'h08;
  localparam logic [7:0] StAddrWAck  = 8'h18;
  localparam logic [7:0] StDataAck   = 8'h28;
  localparam logic [7:0] StRestart   = 8'h10;
  localparam logic [7:0] StAddrRAck  = 8'h40;
  localparam logic [7:0] StRdataAck  = 8'h50;

  // bus actions
  localparam logic [ActW-1:0] ActNone  = 3'd0;
  localparam logic [ActW-1:0] ActStart = 3'd1;
  localparam logic [ActW-1:0] ActSend  = 3'd2;
  localparam logic [ActW-1:0] ActRecv  = 3'd3;
  localparam logic [ActW-1:0] ActStop  = 3'd4;

  // result codes
  localparam logic [CodeW-1:0] ResOk          = 3'd0;
  localparam logic [CodeW-1:0] ResBadParams   = 3'd1;
  localparam logic [CodeW-1:0] ResStartFail   = 3'd2;
  localparam logic [CodeW-1:0] ResAddrNack    = 3'd3;
  localparam logic [CodeW-1:0] ResByteNack    = 3'd4;
  localparam logic [CodeW-1:0] ResRestartFail = 3'd5;
  localparam logic [CodeW-1:0] ResRaddrNack   = 3'd6;
  localparam logic [CodeW-1:0] ResReadFail    = 3'd7;

  // request kinds carried in tuser
  localparam logic ReqCommand = 1'b0;
  localparam logic ReqStatus  = 1'b1;

endpackage

// ===== hdl/i2c_register_transfer_sequencer.sv =====
// i2c register transfer sequencer: command and status stream in, bus action stream out
// one input register, single-pass decision logic, one result register
// depends on i2c_rts_pkg
//
// usage
//   slave channel s_axis: one transaction is either a transfer command (tuser 0) or a
//   status event from the i2c byte engine (tuser 1). a command loads device address,
//   register address (1 to 4 bytes) and byte count and asks for START. each status
//   event then yields the next bus action: address bytes, register bytes msb first,
//   write data (wr_byte consumed when data_taken is set) or a repeated START and reads.
//   an unexpected status ends the transfer with STOP and a nonzero result code.
//   master channel m_axis: exactly one result transaction per input transaction, in
//   order; tlast marks the end of a transfer (done), tuser flags a received byte.
// timing
//   a result is registered: the accept edge loads the input register, and the result register
//   is loaded from it on the next edge at which m_axis can take it; one transaction per cycle is
//   sustained while m_axis_tready_i stays high, set by the single phase update between the registers.
// reset and stalls
//   reset empties both registers and returns the sequencer to idle with cleared state.
//   while m_axis_tready_i is low the result register holds; the input register still
//   takes one more transaction, then s_axis_tready_o drops until the result drains.
module i2c_register_transfer_sequencer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave channel
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // device_addr[7:0], register_addr[39:8], addr_len[42:40], data_count[55:43],
  // bus_status[63:56], bus_byte[71:64], wr_byte[79:72]
  input  logic [i2c_rts_pkg::InDataW-1:0]    s_axis_tdata_i,
  // req_type[0]
  input  logic                               s_axis_tuser_i,
  // master channel
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // action[2:0], tx_byte[10:3], rx_byte[18:11], data_taken[19],
  // result_code[22:20], busy_res[23]
  output logic [i2c_rts_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // rx_valid[0]
  output logic                               m_axis_tuser_o,
  // done_res
  output logic                               m_axis_tlast_o
);

  // phase codes
  localparam logic [2:0] PhIdle    = 3'd0;
  localparam logic [2:0] PhStart   = 3'd1;
  localparam logic [2:0] PhAddr    = 3'd2;
  localparam logic [2:0] PhReg     = 3'd3;
  localparam logic [2:0] PhWdata   = 3'd4;
  localparam logic [2:0] PhRestart = 3'd5;
  localparam logic [2:0] PhRaddr   = 3'd6;
  localparam logic [2:0] PhRdata   = 3'd7;

  localparam logic [i2c_rts_pkg::LenW-1:0] MaxLen =
    i2c_rts_pkg::LenW'(i2c_rts_pkg::MaxAddrBytes);
  localparam logic [i2c_rts_pkg::CountW-1:0] MaxCount =
    i2c_rts_pkg::CountW'(i2c_rts_pkg::MaxTransfer);

  // input register
  logic                               in_valid_q;
  logic [i2c_rts_pkg::InDataW-1:0]    in_data_q;
  logic                               in_user_q;

  // result register
  logic                               out_valid_q;
  logic [i2c_rts_pkg::OutDataW-1:0]   out_data_q, out_data_d;
  logic                               out_user_q, out_user_d;
  logic                               out_last_q, out_last_d;

  // sequencer state
  logic [2:0]                         phase_q, phase_d;
  logic [7:0]                         dev_q, dev_d;
  logic [31:0]                        reg_q, reg_d;
  logic [i2c_rts_pkg::LenW-1:0]       abl_q, abl_d;
  logic [i2c_rts_pkg::CountW-1:0]     left_q, left_d;

  logic out_load;
  logic advance;

  // unpacked fields of the held transaction
  logic [7:0]                         f_dev;
  logic [31:0]                        f_reg;
  logic [i2c_rts_pkg::LenW-1:0]       f_len;
  logic [i2c_rts_pkg::CountW-1:0]     f_cnt;
  logic [7:0]                         f_status;
  logic [7:0]                         f_rbyte;
  logic [7:0]                         f_wbyte;

  // decision outputs
  logic [i2c_rts_pkg::ActW-1:0]       act;
  logic [7:0]                         tx;
  logic [7:0]                         rx;
  logic                               rxv;
  logic                               taken;
  logic                               done;
  logic [i2c_rts_pkg::CodeW-1:0]      code;
  logic [i2c_rts_pkg::CodeW-1:0]      fail;

  // next register address byte, msb first
  logic [i2c_rts_pkg::LenW-1:0]       abl_dec;
  logic [7:0]                         reg_byte;
  logic [i2c_rts_pkg::CountW-1:0]     left_dec;
  logic                               bad_cmd;

  assign f_dev    = in_data_q[7:0];
  assign f_reg    = in_data_q[39:8];
  assign f_len    = in_data_q[42:40];
  assign f_cnt    = in_data_q[55:43];
  assign f_status = in_data_q[63:56];
  assign f_rbyte  = in_data_q[71:64];
  assign f_wbyte  = in_data_q[79:72];

  assign out_load        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_load;
  assign s_axis_tready_o = !in_valid_q || advance;

  assign abl_dec  = abl_q - 1'b1;
  assign reg_byte = reg_q[{abl_dec[1:0], 3'b000} +: 8];
  assign left_dec = left_q - 1'b1;
  assign bad_cmd  = (f_len == '0) || (f_len > MaxLen) ||
                    (f_cnt == '0) || (f_cnt > MaxCount);

  always_comb begin
    phase_d = phase_q;
    dev_d   = dev_q;
    reg_d   = reg_q;
    abl_d   = abl_q;
    left_d  = left_q;
    act     = i2c_rts_pkg::ActNone;
    tx      = '0;
    rx      = '0;
    rxv     = 1'b0;
    taken   = 1'b0;
    done    = 1'b0;
    code    = i2c_rts_pkg::ResOk;
    fail    = i2c_rts_pkg::ResOk;

    if (in_user_q == i2c_rts_pkg::ReqCommand) begin
      // a command while busy is dropped
      if (phase_q == PhIdle) begin
        if (bad_cmd) begin
          done = 1'b1;
          code = i2c_rts_pkg::ResBadParams;
        end else begin
          dev_d   = f_dev;
          reg_d   = f_reg;
          abl_d   = f_len;
          left_d  = f_cnt;
          act     = i2c_rts_pkg::ActStart;
          phase_d = PhStart;
        end
      end
    end else begin
      unique case (phase_q)
        PhStart: begin
          if (f_status == i2c_rts_pkg::StStart) begin
            act     = i2c_rts_pkg::ActSend;
            tx      = {dev_q[7:1], 1'b0};
            phase_d = PhAddr;
          end else begin
            fail = i2c_rts_pkg::ResStartFail;
          end
        end
        PhAddr: begin
          if (f_status == i2c_rts_pkg::StAddrWAck) begin
            act     = i2c_rts_pkg::ActSend;
            tx      = reg_byte;
            abl_d   = abl_dec;
            phase_d = PhReg;
          end else begin
            fail = i2c_rts_pkg::ResAddrNack;
          end
        end
        PhReg: begin
          priority if (f_status != i2c_rts_pkg::StDataAck) begin
            fail = i2c_rts_pkg::ResByteNack;
          end else if (abl_q != '0) begin
            act   = i2c_rts_pkg::ActSend;
            tx    = reg_byte;
            abl_d = abl_dec;
          end else if (dev_q[0]) begin
            act     = i2c_rts_pkg::ActStart;
            phase_d = PhRestart;
          end else begin
            act     = i2c_rts_pkg::ActSend;
            tx      = f_wbyte;
            taken   = 1'b1;
            left_d  = left_dec;
            phase_d = PhWdata;
          end
        end
        PhWdata: begin
          priority if (f_status != i2c_rts_pkg::StDataAck) begin
            fail = i2c_rts_pkg::ResByteNack;
          end else if (left_q != '0) begin
            act    = i2c_rts_pkg::ActSend;
            tx     = f_wbyte;
            taken  = 1'b1;
            left_d = left_dec;
          end else begin
            act     = i2c_rts_pkg::ActStop;
            done    = 1'b1;
            phase_d = PhIdle;
          end
        end
        PhRestart: begin
          if (f_status == i2c_rts_pkg::StRestart) begin
            act     = i2c_rts_pkg::ActSend;
            tx      = dev_q;
            phase_d = PhRaddr;
          end else begin
            fail = i2c_rts_pkg::ResRestartFail;
          end
        end
        PhRaddr: begin
          if (f_status == i2c_rts_pkg::StAddrRAck) begin
            act     = i2c_rts_pkg::ActRecv;
            phase_d = PhRdata;
          end else begin
            fail = i2c_rts_pkg::ResRaddrNack;
          end
        end
        PhRdata: begin
          if (f_status == i2c_rts_pkg::StRdataAck) begin
            rx     = f_rbyte;
            rxv    = 1'b1;
            left_d = left_dec;
            // last byte is also acked, then stop
            if (left_dec == '0) begin
              act     = i2c_rts_pkg::ActStop;
              done    = 1'b1;
              phase_d = PhIdle;
            end else begin
              act = i2c_rts_pkg::ActRecv;
            end
          end else begin
            fail = i2c_rts_pkg::ResReadFail;
          end
        end
        default: begin
          // status while idle is ignored
          phase_d = PhIdle;
        end
      endcase

      if (fail != i2c_rts_pkg::ResOk) begin
        act     = i2c_rts_pkg::ActStop;
        tx      = '0;
        done    = 1'b1;
        code    = fail;
        phase_d = PhIdle;
      end
    end

    out_data_d = {(phase_d != PhIdle), code, taken, rx, tx, act};
    out_user_d = rxv;
    out_last_d = done;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PhIdle;
      dev_q       <= '0;
      reg_q       <= '0;
      abl_q       <= '0;
      left_q      <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        phase_q <= phase_d;
        dev_q   <= dev_d;
        reg_q   <= reg_d;
        abl_q   <= abl_d;
        left_q  <= left_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
      in_user_q <= s_axis_tuser_i;
    end
    if (advance) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

  // a finished transfer never reports busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> !m_axis_tdata_o[23])
    else $error("done result reports busy");

  // a received byte only comes with a receive or stop action
  a_rx_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (m_axis_tdata_o[2:0] == i2c_rts_pkg::ActRecv ||
       m_axis_tdata_o[2:0] == i2c_rts_pkg::ActStop))
    else $error("rx byte without receive action");

  // write data is consumed only by a send
  a_taken_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[19]) |->
      (m_axis_tdata_o[2:0] == i2c_rts_pkg::ActSend))
    else $error("data taken without send");

  // an error code only ends a transfer
  a_code_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[22:20] != i2c_rts_pkg::ResOk) |-> m_axis_tlast_o)
    else $error("result code without done");

endmodule

// ===== tb/tb_i2c_register_transfer_sequencer.sv =====
// self-checking testbench for the i2c register transfer sequencer
// drives command and status streams, predicts bus actions, checks every result in order
// depends on i2c_rts_pkg and i2c_register_transfer_sequencer
`timescale 1ns / 1ps

module tb_i2c_register_transfer_sequencer;

  // input transaction, payload laid out exactly as s_axis_tdata (device_addr in the low bits)
  typedef struct packed {
    logic [7:0]                     wr_byte;
    logic [7:0]                     bus_byte;
    logic [7:0]                     bus_status;
    logic [i2c_rts_pkg::CountW-1:0] data_count;
    logic [i2c_rts_pkg::LenW-1:0]   addr_len;
    logic [31:0]                    register_addr;
    logic [7:0]                     device_addr;
  } seq_payload_t;

  typedef struct packed {
    logic         req_type;
    seq_payload_t payload;
  } seq_request_t;

  typedef struct packed {
    logic [i2c_rts_pkg::ActW-1:0]  action;
    logic [7:0]                    tx_byte;
    logic [7:0]                    rx_byte;
    logic                          rx_valid;
    logic                          data_taken;
    logic                          done;
    logic [i2c_rts_pkg::CodeW-1:0] result_code;
    logic                          busy;
  } bus_action_t;

  typedef enum logic [2:0] {
    PhIdle, PhStart, PhAddr, PhReg, PhWdata, PhRestart, PhRaddr, PhRdata
  } xfer_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [i2c_rts_pkg::InDataW-1:0]  s_tdata = '0;
  logic                             s_tuser = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [i2c_rts_pkg::OutDataW-1:0] m_tdata;
  logic                             m_tuser;
  logic                             m_tlast;

  seq_request_t pending_requests[$];
  bus_action_t  expected_actions[$];
  int unsigned  mismatches = 0;
  int unsigned  random_items = 0;

  // predictor state, mirrors the sequencer
  xfer_phase_e                    pred_phase = PhIdle;
  logic [7:0]                     pred_dev = '0;
  logic [31:0]                    pred_reg = '0;
  logic [i2c_rts_pkg::LenW-1:0]   pred_addr_left = '0;
  logic [i2c_rts_pkg::CountW-1:0] pred_bytes_left = '0;

  // sender burst/gap control
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned sent_count = 0;

  // receiver stall pattern
  logic [11:0] rx_cycle = '0;
  int unsigned stall_left = 0;

  bus_action_t predicted;
  bus_action_t oldest;

  i2c_register_transfer_sequencer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // register address goes out msb first, each byte cut fresh from the saved address
  function automatic logic [7:0] next_addr_byte();
    logic [1:0] idx;
    idx = 2'(pred_addr_left - 1'b1);
    pred_addr_left = pred_addr_left - 1'b1;
    return pred_reg[idx*8 +: 8];
  endfunction

  task automatic sequencer_step(input seq_request_t rq, output bus_action_t r);
    seq_payload_t                  p;
    logic [i2c_rts_pkg::CodeW-1:0] fail;
    p = rq.payload;
    fail = i2c_rts_pkg::ResOk;
    r = '0;
    if (rq.req_type == i2c_rts_pkg::ReqCommand) begin
      // commands arriving mid-transfer are dropped
      if (pred_phase == PhIdle) begin
        if (p.addr_len < 1 || p.addr_len > i2c_rts_pkg::MaxAddrBytes ||
            p.data_count == 0 || p.data_count > i2c_rts_pkg::MaxTransfer) begin
          r.done = 1'b1;
          r.result_code = i2c_rts_pkg::ResBadParams;
        end else begin
          pred_dev = p.device_addr;
          pred_reg = p.register_addr;
          pred_addr_left = p.addr_len;
          pred_bytes_left = p.data_count;
          r.action = i2c_rts_pkg::ActStart;
          pred_phase = PhStart;
        end
      end
    end else begin
      case (pred_phase)
        PhStart: begin
          if (p.bus_status == i2c_rts_pkg::StStart) begin
            r.action = i2c_rts_pkg::ActSend;
            r.tx_byte = pred_dev & 8'hFE;
            pred_phase = PhAddr;
          end else fail = i2c_rts_pkg::ResStartFail;
        end
        PhAddr: begin
          if (p.bus_status == i2c_rts_pkg::StAddrWAck) begin
            r.action = i2c_rts_pkg::ActSend;
            r.tx_byte = next_addr_byte();
            pred_phase = PhReg;
          end else fail = i2c_rts_pkg::ResAddrNack;
        end
        PhReg: begin
          if (p.bus_status != i2c_rts_pkg::StDataAck) fail = i2c_rts_pkg::ResByteNack;
          else if (pred_addr_left != 0) begin
            r.action = i2c_rts_pkg::ActSend;
            r.tx_byte = next_addr_byte();
          end else if (pred_dev[0]) begin
            // read: repeated start before the address with read bit
            r.action = i2c_rts_pkg::ActStart;
            pred_phase = PhRestart;
          end else begin
            r.action = i2c_rts_pkg::ActSend;
            r.tx_byte = p.wr_byte;
            r.data_taken = 1'b1;
            pred_bytes_left = pred_bytes_left - 1'b1;
            pred_phase = PhWdata;
          end
        end
        PhWdata: begin
          if (p.bus_status != i2c_rts_pkg::StDataAck) fail = i2c_rts_pkg::ResByteNack;
          else if (pred_bytes_left != 0) begin
            r.action = i2c_rts_pkg::ActSend;
            r.tx_byte = p.wr_byte;
            r.data_taken = 1'b1;
            pred_bytes_left = pred_bytes_left - 1'b1;
          end else begin
            r.action = i2c_rts_pkg::ActStop;
            r.done = 1'b1;
            pred_phase = PhIdle;
          end
        end
        PhRestart: begin
          if (p.bus_status == i2c_rts_pkg::StRestart) begin
            r.action = i2c_rts_pkg::ActSend;
            r.tx_byte = pred_dev;
            pred_phase = PhRaddr;
          end else fail = i2c_rts_pkg::ResRestartFail;
        end
        PhRaddr: begin
          if (p.bus_status == i2c_rts_pkg::StAddrRAck) begin
            r.action = i2c_rts_pkg::ActRecv;
            pred_phase = PhRdata;
          end else fail = i2c_rts_pkg::ResRaddrNack;
        end
        PhRdata: begin
          // the last byte is also acked, then stop
          if (p.bus_status == i2c_rts_pkg::StRdataAck) begin
            r.rx_byte = p.bus_byte;
            r.rx_valid = 1'b1;
            pred_bytes_left = pred_bytes_left - 1'b1;
            if (pred_bytes_left == 0) begin
              r.action = i2c_rts_pkg::ActStop;
              r.done = 1'b1;
              pred_phase = PhIdle;
            end else r.action = i2c_rts_pkg::ActRecv;
          end else fail = i2c_rts_pkg::ResReadFail;
        end
        default: pred_phase = PhIdle;
      endcase
      if (fail != i2c_rts_pkg::ResOk) begin
        r.action = i2c_rts_pkg::ActStop;
        r.tx_byte = '0;
        r.done = 1'b1;
        r.result_code = fail;
        pred_phase = PhIdle;
      end
    end
    r.busy = (pred_phase != PhIdle);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic seq_request_t random_request(logic kind);
    seq_request_t rq;
    rq.req_type = kind;
    rq.payload.device_addr = 8'($urandom());
    rq.payload.register_addr = $urandom();
    rq.payload.addr_len = 3'($urandom());
    rq.payload.data_count = 13'($urandom());
    rq.payload.bus_status = 8'($urandom());
    rq.payload.bus_byte = 8'($urandom());
    rq.payload.wr_byte = 8'($urandom());
    return rq;
  endfunction

  task automatic push_command(input logic [7:0] dev, input logic [31:0] reg_val,
                              input logic [i2c_rts_pkg::LenW-1:0] alen,
                              input logic [i2c_rts_pkg::CountW-1:0] cnt);
    seq_request_t rq;
    rq = random_request(i2c_rts_pkg::ReqCommand);
    rq.payload.device_addr = dev;
    rq.payload.register_addr = reg_val;
    rq.payload.addr_len = alen;
    rq.payload.data_count = cnt;
    pending_requests.push_back(rq);
  endtask

  task automatic push_status(input logic [7:0] st);
    seq_request_t rq;
    rq = random_request(i2c_rts_pkg::ReqStatus);
    rq.payload.bus_status = st;
    pending_requests.push_back(rq);
  endtask

  // any status other than the one the current phase waits for
  function automatic logic [7:0] wrong_status(logic [7:0] good);
    logic [7:0] codes[6];
    logic [7:0] w;
    codes = '{i2c_rts_pkg::StStart, i2c_rts_pkg::StAddrWAck, i2c_rts_pkg::StDataAck,
              i2c_rts_pkg::StRestart, i2c_rts_pkg::StAddrRAck, i2c_rts_pkg::StRdataAck};
    if ($urandom_range(0, 1) == 1) w = codes[$urandom_range(0, 5)];
    else w = 8'($urandom());
    if (w == good) w = good ^ 8'h08;
    return w;
  endfunction

  function automatic logic [i2c_rts_pkg::CountW-1:0] bad_count();
    return ($urandom_range(0, 1) == 1) ? '0 :
           13'($urandom_range(i2c_rts_pkg::MaxTransfer + 1, 8191));
  endfunction

  // one well-formed transfer; with a fault one status is corrupted and the rest dropped
  task automatic queue_transfer(input logic [7:0] dev,
                                input logic [i2c_rts_pkg::LenW-1:0] alen,
                                input logic [i2c_rts_pkg::CountW-1:0] cnt,
                                input bit fault);
    logic [7:0]  flow[$];
    int unsigned k;
    flow.push_back(i2c_rts_pkg::StStart);
    flow.push_back(i2c_rts_pkg::StAddrWAck);
    repeat (int'(alen) - 1) flow.push_back(i2c_rts_pkg::StDataAck);
    if (dev[0]) begin
      flow.push_back(i2c_rts_pkg::StDataAck);
      flow.push_back(i2c_rts_pkg::StRestart);
      flow.push_back(i2c_rts_pkg::StAddrRAck);
      repeat (int'(cnt)) flow.push_back(i2c_rts_pkg::StRdataAck);
    end else begin
      repeat (int'(cnt) + 1) flow.push_back(i2c_rts_pkg::StDataAck);
    end
    if (fault) begin
      k = $urandom_range(0, flow.size() - 1);
      flow[k] = wrong_status(flow[k]);
      while (flow.size() > k + 1) flow.pop_back();
    end
    push_command(dev, $urandom(), alen, cnt);
    random_items += 1 + flow.size();
    foreach (flow[i]) begin
      // a stray command while busy now and then, it must be ignored
      if (i != 0 && $urandom_range(0, 24) == 0) begin
        push_command(8'($urandom()), $urandom(), 3'($urandom_range(1, 4)), 13'($urandom()));
        random_items++;
      end
      push_status(flow[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of transactions with random gaps, valid held until accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        sequencer_step(pending_requests[0], predicted);
        expected_actions.push_back(predicted);
        void'(pending_requests.pop_front());
        sent_count++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          // every third stretch of 200 transactions runs without gaps
          if ((sent_count / 200) % 3 == 1 || $urandom_range(0, 2) != 0) gap_left = 0;
          else gap_left = $urandom_range(1, 8);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_requests[0].payload;
        s_tuser <= pending_requests[0].req_type;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: ready pattern cycles through always-ready, random, long stalls, toggling
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_cycle <= '0;
      stall_left = 0;
    end else begin
      rx_cycle <= rx_cycle + 1'b1;
      case (rx_cycle[9:8])
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= ($urandom_range(0, 9) < 7);
        2'd2: begin
          if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
          end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
          end
        end
        default: m_tready <= rx_cycle[1];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // monitor and checker
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < 40)
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_actions.size() == 0) begin
        report_mismatch("unexpected result transaction", 32'(m_tdata), 0);
      end else begin
        oldest = expected_actions.pop_front();
        if (m_tdata[2:0] != oldest.action)
          report_mismatch("action", 32'(m_tdata[2:0]), 32'(oldest.action));
        if (m_tdata[10:3] != oldest.tx_byte)
          report_mismatch("tx_byte", 32'(m_tdata[10:3]), 32'(oldest.tx_byte));
        if (m_tdata[18:11] != oldest.rx_byte)
          report_mismatch("rx_byte", 32'(m_tdata[18:11]), 32'(oldest.rx_byte));
        if (m_tdata[19] != oldest.data_taken)
          report_mismatch("data_taken", 32'(m_tdata[19]), 32'(oldest.data_taken));
        if (m_tdata[22:20] != oldest.result_code)
          report_mismatch("result_code", 32'(m_tdata[22:20]), 32'(oldest.result_code));
        if (m_tdata[23] != oldest.busy)
          report_mismatch("busy_res", 32'(m_tdata[23]), 32'(oldest.busy));
        if (m_tuser != oldest.rx_valid)
          report_mismatch("rx_valid", 32'(m_tuser), 32'(oldest.rx_valid));
        if (m_tlast != oldest.done)
          report_mismatch("done_res", 32'(m_tlast), 32'(oldest.done));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned sel;
    int unsigned r;
    logic [7:0]                     dev;
    logic [i2c_rts_pkg::CountW-1:0] cnt;
    rst_ni = 1'b0;

    // directed: status while idle, every kind of bad command
    push_status(i2c_rts_pkg::StStart);
    push_command(8'($urandom()), $urandom(), 3'd0, 13'd1);
    push_command(8'($urandom()), $urandom(), 3'd5, 13'(i2c_rts_pkg::MaxTransfer));
    push_command(8'($urandom()), $urandom(), 3'd7, 13'd8);
    push_command(8'($urandom()), $urandom(), 3'd2, 13'd0);
    push_command(8'($urandom()), $urandom(), 3'd4, 13'(i2c_rts_pkg::MaxTransfer + 1));
    push_command(8'($urandom()), $urandom(), 3'd1, 13'h1FFF);
    // shortest write, with a command arriving while busy
    push_command(8'h00, 32'hFFFF_FFFF, 3'd1, 13'd1);
    push_status(i2c_rts_pkg::StStart);
    push_status(i2c_rts_pkg::StAddrWAck);
    push_status(i2c_rts_pkg::StDataAck);
    push_command(8'hFF, 32'h0, 3'd2, 13'd3);
    push_status(i2c_rts_pkg::StDataAck);
    // read with the widest register address, last byte acked then stop
    push_command(8'hFF, 32'h8000_0001, 3'd4, 13'd2);
    push_status(i2c_rts_pkg::StStart);
    push_status(i2c_rts_pkg::StAddrWAck);
    push_status(i2c_rts_pkg::StDataAck);
    push_status(i2c_rts_pkg::StDataAck);
    push_status(i2c_rts_pkg::StDataAck);
    push_status(i2c_rts_pkg::StDataAck);
    push_status(i2c_rts_pkg::StRestart);
    push_status(i2c_rts_pkg::StAddrRAck);
    push_status(i2c_rts_pkg::StRdataAck);
    push_status(i2c_rts_pkg::StRdataAck);

    // largest legal count, cut short by a data nack after a few bytes
    push_command(8'h5A, $urandom(), 3'd4, 13'(i2c_rts_pkg::MaxTransfer));
    push_status(i2c_rts_pkg::StStart);
    push_status(i2c_rts_pkg::StAddrWAck);
    repeat (6) push_status(i2c_rts_pkg::StDataAck);
    push_status(8'h30);

    // random part: mostly well-formed transfers, some faults and noise
    while (random_items < 1450) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        if ($urandom_range(0, 1) == 1)
          push_command(8'($urandom()), $urandom(), 3'($urandom_range(5, 7)) & {3{1'b1}} &
                       (($urandom_range(0, 3) == 0) ? 3'd0 : 3'd7), 13'($urandom_range(1, 64)));
        else
          push_command(8'($urandom()), $urandom(), 3'($urandom_range(1, 4)), bad_count());
        random_items++;
      end else if (sel < 14) begin
        push_status(8'($urandom()));
        random_items++;
      end else begin
        dev = 8'($urandom());
        r = $urandom_range(0, 39);
        if (r == 0) cnt = 13'($urandom_range(65, 300));
        else if (r < 5) cnt = 13'($urandom_range(7, 64));
        else cnt = 13'($urandom_range(1, 6));
        queue_transfer(dev, 3'($urandom_range(1, 4)), cnt, $urandom_range(0, 3) == 0);
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || expected_actions.size() != 0) @(posedge clk_i);
    // two-stage pipeline, spare cycles afterwards catch any extra result
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
